FILE: sv/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg: shared types, constants and font ROM for the text rasterizer
// Holds the 8x8 glyph bitmaps, the descriptor passed from the front end to
// the scanner, the frame-buffer write record and the scanner states.
// ----------------------------------------------------------------------------
package gtr_pkg;

  // Default geometry
  localparam int ScreenWidthDef    = 320;
  localparam int ScreenHeightDef   = 240;
  localparam int MaxStringCharsDef = 64;

  localparam int GlyphCount = 36;
  localparam int GlyphSize  = 8;

  // Queue depths
  localparam int DescDepth = 2;
  localparam int WrDepth   = 4;

  // Glyph bitmaps, row 0 in the top byte, column 0 in the MSB of each row.
  // Entries 0..25 are A..Z, entries 26..35 are 0..9.
  localparam logic [63:0] GLYPH_ROM [0:GlyphCount-1] = '{
    64'h183C66667E666600, 64'h7C66667C66667C00, 64'h3C66606060663C00,
    64'h786C6666666C7800, 64'h7E60607860607E00, 64'h7E60607860606000,
    64'h3C66606E66663E00, 64'h6666667E66666600, 64'h3E18181818183E00,
    64'h1E0C0C0C0C6C3800, 64'h666C7870786C6600, 64'h6060606060607E00,
    64'h63777F6B63636300, 64'h66767E7E6E666600, 64'h3C66666666663C00,
    64'h7C66667C60606000, 64'h3C666666666C3600, 64'h7C66667C6C666600,
    64'h3C60380E06663C00, 64'h7E18181818181800, 64'h6666666666663C00,
    64'h66666666663C1800, 64'h6363636B7F776300, 64'h66663C183C666600,
    64'h6666663C18181800, 64'h7E060C1830607E00, 64'h3C66666666663C00,
    64'h1838181818187E00, 64'h3C66060C30607E00, 64'h3C66061C06663C00,
    64'h0C1C2C4C7E0C0C00, 64'h7E607C0606663C00, 64'h3C607C6666663C00,
    64'h7E060C1830303000, 64'h3C66663C66663C00, 64'h3C66663E06663C00
  };

  // One character ready to scan
  typedef struct packed {
    logic [5:0]         glyph;     // font ROM entry
    logic signed [11:0] x0;        // left pixel column of the glyph cell
    logic signed [9:0]  y0;        // top pixel row of the glyph cell
    logic signed [20:0] row_base;  // y0 * screen width
    logic [7:0]         color;
  } gtr_desc_t;

  // One frame-buffer write
  typedef struct packed {
    logic [16:0] addr;
    logic [7:0]  color;
    logic        last;
  } gtr_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } gtr_bk_state_t;

  // Glyph pixel at scan index idx (row * 8 + column); unknown glyphs are blank
  function automatic logic glyph_bit(input logic [5:0] glyph, input logic [5:0] idx);
    logic [63:0] bits;
    bits = (glyph < 6'(GlyphCount)) ? GLYPH_ROM[glyph] : 64'h0;
    return bits[6'd63 - idx];
  endfunction

endpackage

FILE: sv/gtr_fifo.sv
// ----------------------------------------------------------------------------
// gtr_fifo: small first-in first-out queue
// Register-based queue with full and empty flags; the head entry is shown
// combinationally on rdata while empty is low.
// ----------------------------------------------------------------------------
module gtr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/gtr_front.sv
// ----------------------------------------------------------------------------
// gtr_front: character classifier
// Maps the character code to a font entry, drops undrawable characters and
// characters past the string limit, and builds the scan descriptor with the
// glyph cell origin and the row base address.
// ----------------------------------------------------------------------------
module gtr_front #(
  parameter int SCREEN_WIDTH     = gtr_pkg::ScreenWidthDef,
  parameter int MAX_STRING_CHARS = gtr_pkg::MaxStringCharsDef
) (
  input  logic                signed [10:0] in_base_x,
  input  logic                signed [9:0]  in_base_y,
  input  logic                       [5:0]  in_char_position,
  input  logic                       [7:0]  in_char_code,
  input  logic                       [7:0]  in_pixel_color,
  input  logic                              in_push,
  output logic                              in_full,
  output logic                              desc_push,
  output gtr_pkg::gtr_desc_t                desc,
  input  logic                              desc_full
);
  import gtr_pkg::*;

  localparam logic signed [20:0] WidthS = 21'(SCREEN_WIDTH);
  localparam logic [6:0]         MaxPos = 7'(MAX_STRING_CHARS);

  logic       is_upper, is_digit, drawable;
  logic [5:0] glyph;

  // Classify the character code
  always_comb begin
    is_upper = (in_char_code >= 8'h41) && (in_char_code <= 8'h5A);
    is_digit = (in_char_code >= 8'h30) && (in_char_code <= 8'h39);
    if (is_upper) begin
      glyph = 6'(in_char_code - 8'h41);
    end else begin
      glyph = 6'(in_char_code - 8'h30) + 6'd26;
    end
    drawable = (is_upper || is_digit) && ({1'b0, in_char_position} < MaxPos);
  end

  // Build the descriptor: cell origin and row base address
  always_comb begin
    desc.glyph    = glyph;
    desc.x0       = 12'(in_base_x) + $signed({3'b000, in_char_position, 3'b000});
    desc.y0       = in_base_y;
    desc.row_base = 21'(in_base_y) * WidthS;
    desc.color    = in_pixel_color;
  end

  // Accept while the descriptor queue has room; undrawable items vanish here
  assign in_full   = desc_full;
  assign desc_push = in_push && !desc_full && drawable;

endmodule

FILE: sv/gtr_back.sv
// ----------------------------------------------------------------------------
// gtr_back: glyph scanner
// Walks the 64 pixels of one glyph, one a cycle unless the output queue is
// full, clips against the screen, and holds each visible write until the
// next one (or the glyph end) shows whether it is the last of the character.
// ----------------------------------------------------------------------------
module gtr_back #(
  parameter int SCREEN_WIDTH  = gtr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = gtr_pkg::ScreenHeightDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gtr_pkg::gtr_desc_t desc,
  input  logic               desc_empty,
  output logic               desc_pop,
  output gtr_pkg::gtr_wr_t   wr,
  output logic               wr_push,
  input  logic               wr_full
);
  import gtr_pkg::*;

  localparam logic signed [11:0] WidthX  = 12'(SCREEN_WIDTH);
  localparam logic signed [10:0] HeightY = 11'(SCREEN_HEIGHT);
  localparam logic signed [20:0] WidthR  = 21'(SCREEN_WIDTH);

  gtr_bk_state_t      state_r, state_nxt;
  logic [5:0]         idx_r, idx_nxt;
  gtr_desc_t          desc_r, desc_nxt;
  logic signed [20:0] row_base_r, row_base_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [16:0]        pend_addr_r, pend_addr_nxt;
  logic [7:0]         pend_color_r, pend_color_nxt;

  logic [2:0]         row, col;
  logic signed [11:0] pix_x;
  logic signed [10:0] pix_y;
  logic signed [20:0] addr_sum;
  logic               visible, load;

  // Current pixel position and clip test
  always_comb begin
    row      = idx_r[5:3];
    col      = idx_r[2:0];
    pix_x    = desc_r.x0 + $signed({9'b0, col});
    pix_y    = 11'(desc_r.y0) + $signed({8'b0, row});
    addr_sum = row_base_r + 21'(pix_x);
    visible  = glyph_bit(desc_r.glyph, idx_r) &&
               !pix_x[11] && (pix_x < WidthX) &&
               !pix_y[10] && (pix_y < HeightY);
  end

  // Next state and outputs
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    desc_nxt       = desc_r;
    row_base_nxt   = row_base_r;
    pend_vld_nxt   = pend_vld_r;
    pend_addr_nxt  = pend_addr_r;
    pend_color_nxt = pend_color_r;
    wr_push        = 1'b0;
    wr.addr        = pend_addr_r;
    wr.color       = pend_color_r;
    wr.last        = 1'b0;
    load           = 1'b0;

    case (state_r)
      BK_IDLE: begin
        load = !desc_empty;
      end
      BK_SCAN: begin
        if (!wr_full) begin
          if (visible) begin
            wr_push        = pend_vld_r;
            pend_vld_nxt   = 1'b1;
            pend_addr_nxt  = addr_sum[16:0];
            pend_color_nxt = desc_r.color;
          end
          idx_nxt = idx_r + 1'b1;
          if (col == 3'd7) begin
            row_base_nxt = row_base_r + WidthR;
          end
          if (idx_r == 6'd63) begin
            state_nxt = BK_FLUSH;
          end
        end
      end
      BK_FLUSH: begin
        if (!pend_vld_r || !wr_full) begin
          wr_push      = pend_vld_r;
          wr.last      = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = BK_IDLE;
          load         = !desc_empty;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Take the next character
    if (load) begin
      desc_nxt     = desc;
      row_base_nxt = desc.row_base;
      idx_nxt      = '0;
      state_nxt    = BK_SCAN;
    end
    desc_pop = load;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    desc_r       <= desc_nxt;
    row_base_r   <= row_base_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_color_r <= pend_color_nxt;
  end

  // A write never goes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_push |-> !wr_full)
    else $error("write pushed into full output queue");

  // A descriptor is only taken when one is waiting
  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    desc_pop |-> !desc_empty)
    else $error("descriptor popped from empty queue");

  // The end-of-character mark only leaves in the flush step
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_push && wr.last) |-> (state_r == BK_FLUSH))
    else $error("last write outside flush");

  // The final glyph pixel leads to the flush step
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN && idx_r == 6'd63 && !wr_full) |=> (state_r == BK_FLUSH))
    else $error("scan end did not flush");

  // Nothing stays held once the scanner is idle
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> !pend_vld_r)
    else $error("held write left behind");

endmodule

FILE: sv/glyph_text_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_text_rasterizer: 8x8 font text rasterizer
// Turns one character of a string into clipped frame-buffer pixel writes.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   input   | in_push/in_full, in_base_x .. in_pixel_color | in
//   result  | out_pop/out_empty, out_pixel_address,        | out
//           | out_write_color, out_last_write              |
//
// A drawable character holds the scanner for 64 glyph pixels, one a cycle
// while not stalled, plus a flush step that releases the held final write.
// Undrawable characters are dropped at the input and take no scanner time.
// Input transactions are taken one a cycle while the 2-entry descriptor
// queue has room; a full 4-entry output queue stalls the scanner in place.
// Synchronous active-low reset empties both queues and idles the scanner.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer #(
  parameter int SCREEN_WIDTH     = gtr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT    = gtr_pkg::ScreenHeightDef,
  parameter int MAX_STRING_CHARS = gtr_pkg::MaxStringCharsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [10:0] in_base_x,
  input  logic signed [9:0]  in_base_y,
  input  logic        [5:0]  in_char_position,
  input  logic        [7:0]  in_char_code,
  input  logic        [7:0]  in_pixel_color,
  output logic               out_empty,
  input  logic               out_pop,
  output logic        [16:0] out_pixel_address,
  output logic        [7:0]  out_write_color,
  output logic               out_last_write
);
  import gtr_pkg::*;

  gtr_desc_t desc_in, desc_out;
  logic      desc_push, desc_full, desc_pop, desc_empty;
  gtr_wr_t   wr_in, wr_out;
  logic      wr_push, wr_full;

  // Classify and queue characters
  gtr_front #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .MAX_STRING_CHARS(MAX_STRING_CHARS)
  ) u_front (
    .in_base_x       (in_base_x),
    .in_base_y       (in_base_y),
    .in_char_position(in_char_position),
    .in_char_code    (in_char_code),
    .in_pixel_color  (in_pixel_color),
    .in_push         (in_push),
    .in_full         (in_full),
    .desc_push       (desc_push),
    .desc            (desc_in),
    .desc_full       (desc_full)
  );

  gtr_fifo #(
    .WIDTH($bits(gtr_desc_t)),
    .DEPTH(DescDepth)
  ) u_desc_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (desc_push),
    .wdata(desc_in),
    .full (desc_full),
    .pop  (desc_pop),
    .rdata(desc_out),
    .empty(desc_empty)
  );

  // Scan glyphs into writes
  gtr_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc      (desc_out),
    .desc_empty(desc_empty),
    .desc_pop  (desc_pop),
    .wr        (wr_in),
    .wr_push   (wr_push),
    .wr_full   (wr_full)
  );

  // Decouple the result side
  gtr_fifo #(
    .WIDTH($bits(gtr_wr_t)),
    .DEPTH(WrDepth)
  ) u_wr_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (wr_push),
    .wdata(wr_in),
    .full (wr_full),
    .pop  (out_pop),
    .rdata(wr_out),
    .empty(out_empty)
  );

  assign out_pixel_address = wr_out.addr;
  assign out_write_color   = wr_out.color;
  assign out_last_write    = wr_out.last;

endmodule
